@@ hw/rtl/tlpq_pkg.sv @@
// tlpq_pkg: shared types and constants of the three-level priority queue
// no dependencies; imported by tlpq_mem and three_level_priority_queue_core
package tlpq_pkg;

  localparam int TLPQ_DEPTH = 16;
  localparam int NUM_LEVELS = 3;
  localparam int DATA_W     = 32;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPRI = 2'd3
  } status_t;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_3    = 2'd3;

endpackage

@@ hw/rtl/tlpq_mem.sv @@
// tlpq_mem: value store, one write port and one registered read port
// depends on tlpq_pkg for the data width and the default word count
module tlpq_mem import tlpq_pkg::*; #(
  parameter int WORDS  = NUM_LEVELS * TLPQ_DEPTH,
  parameter int ADDR_W = $clog2(WORDS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/three_level_priority_queue_core.sv @@
// three_level_priority_queue_core: strict priority queue, three fifo levels
// a result is registered and becomes valid in the cycle after its input transfer
// throughput: one item per cycle; the output register stalls the input only when full and held
// reset: synchronous, clears pointers, counts and the output valid; the store is not cleared
// depends on tlpq_pkg and tlpq_mem
module three_level_priority_queue_core import tlpq_pkg::*; #(
  parameter int DEPTH = TLPQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] value,
  input  logic [1:0]         priority_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] data_out,
  output logic [1:0]         served_level,
  output logic [1:0]         status
);

  localparam int WORDS  = NUM_LEVELS * DEPTH;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [PTR_W-1:0] head [NUM_LEVELS];
  logic [PTR_W-1:0] tail [NUM_LEVELS];
  logic [CNT_W-1:0] cnt  [NUM_LEVELS];
  logic [PTR_W-1:0] head_next [NUM_LEVELS];
  logic [PTR_W-1:0] tail_next [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_next  [NUM_LEVELS];

  logic              res_valid;
  status_t           res_status;
  logic [1:0]        res_level;
  logic              res_hit;
  logic [DATA_W-1:0] rd_data;

  logic              xfer_in;
  logic [1:0]        q_enq;
  logic [1:0]        q_deq;
  logic              deq_any;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  status_t           st_next;
  logic [1:0]        lvl_next;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    if ({1'b0, p} == (PTR_W + 1)'(DEPTH - 1)) begin
      return '0;
    end
    return PTR_W'(p + 1'b1);
  endfunction

  assign in_stall = res_valid & out_stall;
  assign xfer_in  = in_valid & ~in_stall;

  assign q_enq   = priority_req - 2'd1;
  assign deq_any = (cnt[2] != '0) | (cnt[1] != '0) | (cnt[0] != '0);

  always_comb begin
    priority if (cnt[2] != '0) begin
      q_deq = 2'd2;
    end else if (cnt[1] != '0) begin
      q_deq = 2'd1;
    end else begin
      q_deq = 2'd0;
    end
  end

  assign wr_addr = ADDR_W'(ADDR_W'(q_enq) * ADDR_W'(DEPTH) + ADDR_W'(tail[q_enq]));
  assign rd_addr = ADDR_W'(ADDR_W'(q_deq) * ADDR_W'(DEPTH) + ADDR_W'(head[q_deq]));

  always_comb begin
    head_next = head;
    tail_next = tail;
    cnt_next  = cnt;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    st_next   = ST_OK;
    lvl_next  = LVL_NONE;
    unique case (mode)
      MODE_ENQ: begin
        priority if (priority_req == LVL_NONE) begin
          st_next = ST_BADPRI;
        end else if (cnt[q_enq] == CNT_W'(DEPTH)) begin
          st_next = ST_FULL;
        end else begin
          wr_en            = xfer_in;
          tail_next[q_enq] = advance(tail[q_enq]);
          cnt_next[q_enq]  = cnt[q_enq] + 1'b1;
          lvl_next         = priority_req;
        end
      end
      MODE_DEQ: begin
        if (deq_any) begin
          rd_en            = xfer_in;
          head_next[q_deq] = advance(head[q_deq]);
          cnt_next[q_deq]  = cnt[q_deq] - 1'b1;
          lvl_next         = q_deq + 2'd1;
        end else begin
          st_next = ST_EMPTY;
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
      res_valid <= 1'b0;
    end else begin
      if (xfer_in) begin
        head <= head_next;
        tail <= tail_next;
        cnt  <= cnt_next;
      end
      if (xfer_in) begin
        res_valid <= 1'b1;
      end else if (!out_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_in) begin
      res_status <= st_next;
      res_level  <= lvl_next;
      res_hit    <= rd_en;
    end
  end

  tlpq_mem #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid    = res_valid;
  assign data_out     = res_hit ? rd_data : '0;
  assign served_level = res_level;
  assign status       = res_status;

  // a served level goes with an ok status and nothing else
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_status == ST_OK) == (res_level != LVL_NONE)))
    else $error("served level and status disagree");

  // dequeue with every level empty must report empty
  assert property (@(posedge clk) disable iff (rst)
    (xfer_in && mode == MODE_DEQ && !deq_any) |=> (res_status == ST_EMPTY))
    else $error("empty dequeue not reported");

  // no level ever holds more than the depth
  assert property (@(posedge clk) disable iff (rst)
    (cnt[0] <= CNT_W'(DEPTH)) && (cnt[1] <= CNT_W'(DEPTH)) && (cnt[2] <= CNT_W'(DEPTH)))
    else $error("level count above depth");

  // a full top level (level 3) refuses an enqueue and keeps its count
  assert property (@(posedge clk) disable iff (rst)
    (xfer_in && mode == MODE_ENQ && priority_req == LVL_3 && cnt[2] == CNT_W'(DEPTH))
      |=> (cnt[2] == CNT_W'(DEPTH)) && (res_status == ST_FULL))
    else $error("enqueue to full level accepted");

endmodule
